@@ rtl/utf16_to_utf8_transcoder_top_assert.svh @@
// Assertion macros shared by the transcoder RTL files.
// Depends on nothing; included by the modules that check their own logic.
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define U2U8_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define U2U8_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define U2U8_ASSERT(label, clk, rst_n, prop, msg)
`define U2U8_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/u2u8_pkg.sv @@
// Shared types, constants and UTF-8 encode functions of the transcoder.
// Depends on nothing; used by every module of the block.
package u2u8_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int MAX_BYTES = 6;

    localparam logic [15:0] SIZE_RESET = 16'd256;
    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] HIGH_LAST = 16'hdbff;
    localparam logic [15:0] LOW_FIRST = 16'hdc00;
    localparam logic [15:0] LOW_LAST = 16'hdfff;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] CONT = 8'h80;

    typedef logic [3:0][7:0] char_bytes_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] content;
        logic [15:0] start_addr;
        logic [2:0] n_content;
        logic nul0_en;
        logic [15:0] nul1_addr;
        logic [2:0] total;
    } cmd_t;

    function automatic logic [2:0] enc_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp < 21'h80) begin
            len = 3'd1;
        end else if (cp < 21'h800) begin
            len = 3'd2;
        end else if (cp < 21'h10000) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic char_bytes_t enc_bytes(input logic [20:0] cp);
        char_bytes_t b;
        b = '0;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            b[0] = LEAD2 | {3'b000, cp[10:6]};
            b[1] = CONT | {2'b00, cp[5:0]};
        end else if (cp < 21'h10000) begin
            b[0] = LEAD3 | {4'b0000, cp[15:12]};
            b[1] = CONT | {2'b00, cp[11:6]};
            b[2] = CONT | {2'b00, cp[5:0]};
        end else begin
            b[0] = LEAD4 | {5'b00000, cp[20:18]};
            b[1] = CONT | {2'b00, cp[17:12]};
            b[2] = CONT | {2'b00, cp[11:6]};
            b[3] = CONT | {2'b00, cp[5:0]};
        end
        return b;
    endfunction

endpackage

@@ rtl/u2u8_fifo.sv @@
// Short command queue between the front classifier and the byte emitter.
// Depends on u2u8_pkg and the assertion macro header.
`include "utf16_to_utf8_transcoder_top_assert.svh"

module u2u8_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  u2u8_pkg::cmd_t   wr_cmd,
    output logic             q_full,
    input  logic             rd_en,
    output u2u8_pkg::cmd_t   rd_cmd,
    output logic             q_empty
);

    u2u8_pkg::cmd_t mem_reg [u2u8_pkg::QDEPTH];
    logic [u2u8_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [u2u8_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [u2u8_pkg::QCNT_W-1:0] count_reg;
    logic [u2u8_pkg::QCNT_W-1:0] count_next;

    assign q_full = (count_reg == u2u8_pkg::QCNT_W'(u2u8_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    `U2U8_NEVER(a_no_overflow, clk, rst_n, wr_en && q_full && !rd_en, "queue write while full")
    `U2U8_NEVER(a_no_underflow, clk, rst_n, rd_en && q_empty, "queue read while empty")

endmodule

@@ rtl/u2u8_front.sv @@
// Front part: input beat acceptance, surrogate pairing, fit check and command build.
// Depends on u2u8_pkg; feeds u2u8_fifo.
module u2u8_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [15:0]      code_unit,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             q_full,
    output logic             q_wr,
    output u2u8_pkg::cmd_t   q_cmd
);

    logic [15:0] size_reg;
    logic pending_reg;
    logic pending_next;
    logic [9:0] high_reg;
    logic [9:0] high_next;
    logic [15:0] widx_reg;
    logic [15:0] widx_next;
    logic accept;

    assign full = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        logic [15:0] eff_size;
        logic is_zero;
        logic is_high;
        logic is_low;
        logic [20:0] cp0;
        logic [20:0] cp1;
        logic use0;
        logic use1;
        logic [2:0] len0;
        logic [2:0] len1;
        logic [2:0] le0;
        logic [2:0] le1;
        logic signed [17:0] free0;
        logic signed [17:0] free1;
        u2u8_pkg::char_bytes_t b0;
        u2u8_pkg::char_bytes_t b1;
        logic [2:0] j;

        eff_size = (size_reg == '0) ? 16'd1 : size_reg;
        is_zero = (code_unit == '0);
        is_high = (code_unit >= u2u8_pkg::HIGH_FIRST) && (code_unit <= u2u8_pkg::HIGH_LAST);
        is_low = (code_unit >= u2u8_pkg::LOW_FIRST) && (code_unit <= u2u8_pkg::LOW_LAST);

        cp0 = {5'b0, u2u8_pkg::HIGH_FIRST[15:10], high_reg};
        cp1 = {5'b0, code_unit};
        use0 = 1'b0;
        use1 = 1'b0;
        pending_next = pending_reg;
        high_next = high_reg;

        if (is_zero) begin
            use0 = pending_reg;
            pending_next = 1'b0;
            high_next = '0;
        end else if (pending_reg) begin
            pending_next = 1'b0;
            high_next = '0;
            use0 = 1'b1;
            if (is_low) begin
                cp0 = {1'b0, high_reg, code_unit[9:0]} + u2u8_pkg::SUPP_BASE;
            end else begin
                use1 = 1'b1;
            end
        end else if (is_high) begin
            pending_next = 1'b1;
            high_next = code_unit[9:0];
        end else begin
            cp0 = {5'b0, code_unit};
            use0 = 1'b1;
        end

        len0 = use0 ? u2u8_pkg::enc_len(cp0) : 3'd0;
        len1 = use1 ? u2u8_pkg::enc_len(cp1) : 3'd0;
        b0 = u2u8_pkg::enc_bytes(cp0);
        b1 = u2u8_pkg::enc_bytes(cp1);

        free0 = $signed({2'b00, eff_size}) - 18'sd1 - $signed({2'b00, widx_reg});
        le0 = (free0 >= $signed({15'b0, len0})) ? len0 : 3'd0;
        free1 = free0 - $signed({15'b0, le0});
        le1 = (free1 >= $signed({15'b0, len1})) ? len1 : 3'd0;

        for (int i = 0; i < u2u8_pkg::MAX_BYTES; i++) begin
            j = 3'(i) - le0;
            if (3'(i) < le0) begin
                q_cmd.content[i] = b0[i[1:0]];
            end else if (j < le1) begin
                q_cmd.content[i] = b1[j[1:0]];
            end else begin
                q_cmd.content[i] = '0;
            end
        end

        q_cmd.start_addr = widx_reg;
        q_cmd.n_content = le0 + le1;
        q_cmd.nul0_en = is_zero && (free1 >= 18'sd0);
        q_cmd.nul1_addr = eff_size - 16'd1;
        q_cmd.total = le0 + le1 + {2'b00, q_cmd.nul0_en} + {2'b00, is_zero};

        widx_next = is_zero ? 16'd0 : widx_reg + {13'b0, q_cmd.n_content};
        q_wr = accept && (q_cmd.total != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            size_reg <= u2u8_pkg::SIZE_RESET;
            pending_reg <= 1'b0;
            high_reg <= '0;
            widx_reg <= '0;
        end else begin
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (accept) begin
                pending_reg <= pending_next;
                high_reg <= high_next;
                widx_reg <= widx_next;
            end
        end
    end

endmodule

@@ rtl/u2u8_back.sv @@
// Back part: walks one queued command and emits its bytes, one result beat per cycle while pop is high.
// Depends on u2u8_pkg and the assertion macro header; reads from u2u8_fifo.
`include "utf16_to_utf8_transcoder_top_assert.svh"

module u2u8_back (
    input  logic             clk,
    input  logic             rst_n,
    input  u2u8_pkg::cmd_t   head,
    input  logic             q_empty,
    output logic             q_rd,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_byte,
    output logic [15:0]      byte_addr,
    output logic             string_done,
    output logic             last
);

    logic valid_reg;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [7:0] byte_reg;
    logic [15:0] addr_reg;
    logic done_reg;
    logic last_reg;
    logic advance;
    logic take;
    logic [7:0] slot_byte;
    logic [15:0] slot_addr;
    logic slot_done;
    logic slot_last;

    assign empty = !valid_reg;
    assign out_byte = byte_reg;
    assign byte_addr = addr_reg;
    assign string_done = done_reg;
    assign last = last_reg;

    assign advance = !valid_reg || pop;
    assign take = advance && !q_empty;
    assign q_rd = take && slot_last;

    always_comb
    begin
        slot_byte = '0;
        for (int i = 0; i < u2u8_pkg::MAX_BYTES; i++) begin
            if (step_reg == 3'(i)) begin
                slot_byte = head.content[i];
            end
        end
        slot_done = (step_reg >= head.n_content);
        if (slot_done) begin
            slot_byte = '0;
        end
        if (!slot_done || (step_reg == head.n_content && head.nul0_en)) begin
            slot_addr = head.start_addr + {13'b0, step_reg};
        end else begin
            slot_addr = head.nul1_addr;
        end
        slot_last = (step_reg == head.total - 3'd1);
        step_next = step_reg;
        if (take) begin
            step_next = slot_last ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (advance) begin
                valid_reg <= !q_empty;
            end
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            byte_reg <= slot_byte;
            addr_reg <= slot_addr;
            done_reg <= slot_done;
            last_reg <= slot_last;
        end
    end

    `U2U8_ASSERT(a_step_in_range, clk, rst_n, !q_empty |-> (step_reg < head.total), "step past command end")
    `U2U8_ASSERT(a_pop_marks_last, clk, rst_n, q_rd |=> (valid_reg && last_reg), "command retired without last beat")
    `U2U8_ASSERT(a_step_idle_zero, clk, rst_n, q_empty |-> (step_reg == '0), "step not cleared between commands")

endmodule

@@ rtl/utf16_to_utf8_transcoder_top.sv @@
// UTF-16 to UTF-8 transcoder top level: a push/full input queue face and an empty/pop
// result queue face. Each input beat is one UTF-16 code unit; each result beat is one byte
// with its buffer address, a string_done flag on terminator NULs and a last flag.
// A high surrogate is held until the next code unit; a valid pair gives four bytes.
// A character that does not fit in buffer_size less one byte is dropped whole.
// Code unit zero flushes a held surrogate, writes a NUL at the write index (if it lies
// inside the buffer) and a NUL at buffer_size-1, and restarts the index at zero.
// The front accepts one code unit per cycle while the two-entry command queue has room.
// The first result beat of a code unit passes through the command queue and the output
// register before it shows on the output ports.
// The emitter sends one byte per cycle while pop is high; a code unit gives one to six
// result beats, and a held high surrogate or a dropped character gives no beat.
// When pop stays low the output register holds, the queue fills and full rises.
// Reset sets buffer_size to 256, clears the held surrogate, the index and the queue.
// Depends on u2u8_pkg, u2u8_front, u2u8_fifo and u2u8_back.
module utf16_to_utf8_transcoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [15:0] byte_addr,
    output logic        string_done,
    output logic        last,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    u2u8_pkg::cmd_t wr_cmd;
    u2u8_pkg::cmd_t head_cmd;
    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;

    u2u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .code_unit (code_unit),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_cmd     (wr_cmd)
    );

    u2u8_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_cmd  (wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_cmd  (head_cmd),
        .q_empty (q_empty)
    );

    u2u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .byte_addr   (byte_addr),
        .string_done (string_done),
        .last        (last)
    );

endmodule
